// ----- design/dts_pkg.sv -----
// Package with types and constants of the delay task scheduler.
package dts_pkg;

	localparam int TASK_COUNT_DEF = 8;
	localparam logic [31:0] FRAME_BYTES = 32'd64;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_WAIT   = 2'd1,
		CMD_SWITCH = 2'd2,
		CMD_START  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] now_tick;
		logic [31:0] delay_ms;
		logic [31:0] stack_value;
		logic [2:0]  load_index;
	} in_item_t;

	typedef struct packed {
		logic [31:0] next_stack;
		logic [2:0]  next_index;
	} out_item_t;

endpackage

// ----- design/dts_ram.sv -----
// Simple dual-port RAM, one write port and one registered read port.
module dts_ram #(
	parameter int DEPTH = dts_pkg::TASK_COUNT_DEF,
	parameter int WIDTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	import dts_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/delay_task_scheduler.sv -----
// Top level of the delay task scheduler.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_item  (dts_pkg::in_item_t)
//  out      output     out_valid / out_ready  out_item (dts_pkg::out_item_t)
//
// Load and wait: accept, then DONE, then the result goes to the output register.
// Switch and start: accept, then SCAN reads the wake-tick RAM (one registered
// read port) once for each task below the idle task, then FETCH reads the stack
// RAM, then DONE loads the result into the output register.
// Reset marks every task ready with a zero wake tick and makes task 0 current.
// A result waits in the output register while the next item is accepted.
module delay_task_scheduler #(
	parameter int TASK_COUNT = dts_pkg::TASK_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dts_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output dts_pkg::out_item_t  out_item
);
	import dts_pkg::*;

	localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDLE_IDX = IDX_W'(TASK_COUNT - 1);

	state_t                  state_q;
	state_t                  state_d;
	cmd_t                    in_cmd;
	cmd_t                    cmd_q;
	logic [31:0]             now_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        idx_s1;
	logic                    chk_s1;
	logic                    hit_q;
	logic [IDX_W-1:0]        pick_q;
	logic [IDX_W-1:0]        cur_q;
	logic [TASK_COUNT-1:0]   ready_q;
	logic [TASK_COUNT-1:0]   wake_vld_q;
	out_item_t               res_q;
	out_item_t               out_q;
	logic                    out_valid_q;

	logic                    accept;
	logic                    scan_issue;
	logic                    scan_end;
	logic                    out_load;
	logic [2:0]              cur_idx3;
	logic [31:0]             slot_ext;
	logic                    slot_ok;
	logic                    wake_we;
	logic [31:0]             wake_wdata;
	logic [31:0]             wake_rdata;
	logic [31:0]             wake_val;
	logic                    now_ready;
	logic                    stk_we;
	logic [IDX_W-1:0]        stk_waddr;
	logic [31:0]             stk_wdata;
	logic [31:0]             stk_rdata;

	assign in_cmd   = cmd_t'(in_item.command);
	assign accept   = in_valid & in_ready;
	assign cur_idx3 = 3'(32'(cur_q));
	assign slot_ext = 32'(in_item.load_index);
	assign slot_ok  = slot_ext < 32'(TASK_COUNT);

	assign wake_we    = accept && (in_cmd == CMD_WAIT);
	assign wake_wdata = in_item.now_tick + {in_item.delay_ms[30:0], 1'b0};

	assign stk_we    = accept && ((in_cmd == CMD_LOAD && slot_ok) || in_cmd == CMD_SWITCH);
	assign stk_waddr = (in_cmd == CMD_LOAD) ? slot_ext[IDX_W-1:0] : cur_q;
	assign stk_wdata = (in_cmd == CMD_LOAD) ? in_item.stack_value - FRAME_BYTES
	                                        : in_item.stack_value;

	assign wake_val  = wake_vld_q[idx_s1] ? wake_rdata : 32'd0;
	assign now_ready = (cmd_q == CMD_SWITCH) ? (now_q >= wake_val) : ready_q[idx_s1];

	dts_ram #(.DEPTH(TASK_COUNT), .WIDTH(32)) u_wake_ram (
		.clk   (clk),
		.we    (wake_we),
		.waddr (cur_q),
		.wdata (wake_wdata),
		.re    (scan_issue),
		.raddr (idx_q),
		.rdata (wake_rdata)
	);

	dts_ram #(.DEPTH(TASK_COUNT), .WIDTH(32)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (scan_end),
		.raddr (pick_q),
		.rdata (stk_rdata)
	);

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		scan_issue = (state_q == ST_SCAN) && (idx_q != IDLE_IDX);
		scan_end   = (state_q == ST_SCAN) && (idx_q == IDLE_IDX) && !chk_s1;
		out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_LOAD || in_cmd == CMD_WAIT) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_LOAD;
			idx_q       <= '0;
			idx_s1      <= '0;
			chk_s1      <= 1'b0;
			hit_q       <= 1'b0;
			pick_q      <= IDLE_IDX;
			cur_q       <= '0;
			ready_q     <= '1;
			wake_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= scan_issue;
			idx_s1  <= idx_q;
			if (accept) begin
				cmd_q  <= in_cmd;
				idx_q  <= '0;
				hit_q  <= 1'b0;
				pick_q <= IDLE_IDX;
				if (in_cmd == CMD_WAIT) begin
					wake_vld_q[cur_q] <= 1'b1;
				end
			end
			if (scan_issue) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (chk_s1) begin
				if (cmd_q == CMD_SWITCH) begin
					ready_q[idx_s1] <= now_ready;
					if (now_ready) begin
						wake_vld_q[idx_s1] <= 1'b0;
					end
				end
				if (now_ready && !hit_q) begin
					hit_q  <= 1'b1;
					pick_q <= idx_s1;
				end
			end
			if (scan_end) begin
				cur_q <= pick_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_item.now_tick;
			res_q <= '{next_stack: 32'd0, next_index: cur_idx3};
		end
		if (state_q == ST_FETCH) begin
			res_q <= '{next_stack: stk_rdata, next_index: cur_idx3};
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_cmd == CMD_LOAD || in_cmd == CMD_WAIT) |=> state_q == ST_DONE)
		else $error("load or wait did not go straight to result");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q[TASK_COUNT-1])
		else $error("idle task lost its ready flag");

	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < 32'(TASK_COUNT))
		else $error("current task out of range");

	a_pick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		scan_end && !hit_q |-> pick_q == IDLE_IDX)
		else $error("no ready task but idle task not picked");

endmodule
